FILE: rtl/core/assert_macros.svh
// Assertion helpers for the scanner core.
// Each macro expands to one labelled concurrent assertion on clk / arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define CHK_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/core/anb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_pkg
// Shared types and constants of the Annex B unit scanner.
// ----------------------------------------------------------------------------
package anb_pkg;

	localparam int unsigned OFFSET_BITS_DEF = 32;
	localparam int unsigned FIFO_DEPTH      = 4;

	localparam logic [7:0] START_BYTE     = 8'h01;
	localparam logic [7:0] FORBIDDEN_MASK = 8'h80;
	localparam logic [7:0] REF_IDC_MASK   = 8'h60;
	localparam logic [7:0] TYPE_MASK      = 8'h1f;

	localparam logic [4:0] TYPE_IDR = 5'd5;
	localparam logic [4:0] TYPE_SPS = 5'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} anb_byte_t;

	typedef struct packed {
		logic [31:0] start_offset;
		logic [31:0] payload_offset;
		logic [31:0] payload_size;
		logic [1:0]  ref_idc;
		logic [4:0]  unit_type;
		logic        forbidden_set;
		logic        unit_is_key;
		logic        buffer_has_key;
		logic        unit_valid;
		logic        end_of_buffer;
	} anb_rec_t;

	// Records produced by one byte: rec_a first, then rec_b
	typedef struct packed {
		logic [1:0] cnt;
		anb_rec_t   rec_a;
		anb_rec_t   rec_b;
	} anb_push_t;

endpackage

FILE: rtl/core/anb_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_byte_if
// Byte stream channel: one buffer byte and its last-byte flag per transfer.
// ----------------------------------------------------------------------------
interface anb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/anb_rec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_rec_if
// Unit record channel: one record of a found unit per transfer.
// ----------------------------------------------------------------------------
interface anb_rec_if;
	logic        valid;
	logic        ready;
	logic [31:0] start_offset;
	logic [31:0] payload_offset;
	logic [31:0] payload_size;
	logic [1:0]  ref_idc;
	logic [4:0]  unit_type;
	logic        forbidden_set;
	logic        unit_is_key;
	logic        buffer_has_key;
	logic        unit_valid;
	logic        end_of_buffer;

	modport source (
		output valid, output start_offset, output payload_offset, output payload_size,
		output ref_idc, output unit_type, output forbidden_set, output unit_is_key,
		output buffer_has_key, output unit_valid, output end_of_buffer,
		input ready
	);
	modport sink (
		input valid, input start_offset, input payload_offset, input payload_size,
		input ref_idc, input unit_type, input forbidden_set, input unit_is_key,
		input buffer_has_key, input unit_valid, input end_of_buffer,
		output ready
	);
endinterface

FILE: rtl/core/anb_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_in_reg
// Input register: holds one accepted byte until the scan stage consumes it.
// ----------------------------------------------------------------------------
module anb_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	anb_byte_if.sink           stream,
	input  logic               fire,
	output logic               valid_s1,
	output anb_pkg::anb_byte_t byte_s1
);

	logic vld_s1;

	// Take a new byte when the register is empty or being drained
	assign stream.ready = !vld_s1 || fire;
	assign valid_s1     = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (stream.ready) begin
			vld_s1 <= stream.valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1.data_byte <= stream.data_byte;
			byte_s1.last_byte <= stream.last_byte;
		end
	end

endmodule

FILE: rtl/core/anb_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_scan
// Start-code scan: tracks zeros, open unit and header byte, and builds the
// zero, one or two records that each consumed byte produces.
// ----------------------------------------------------------------------------
module anb_scan #(
	parameter int unsigned OFFSET_BITS = anb_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  anb_pkg::anb_byte_t byte_s1,
	output anb_pkg::anb_push_t push
);

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	typedef logic [OFFSET_BITS-1:0] off_t;

	function automatic off_t sat_sub(input off_t a, input off_t b);
		return (a > b) ? off_t'(a - b) : '0;
	endfunction

	function automatic logic [31:0] low32(input off_t x);
		logic [63:0] w;
		w = 64'(x);
		return w[31:0];
	endfunction

	// Build a unit record from offsets and the captured header
	function automatic anb_pkg::anb_rec_t mk_rec(
		input off_t       so,
		input off_t       po,
		input off_t       sz,
		input logic [8:0] hdr,
		input logic       hdr_last,
		input logic       key_prev,
		input logic       eob
	);
		anb_pkg::anb_rec_t r;
		logic [7:0]        h;
		h = hdr[8] ? hdr[7:0] : 8'h00;
		r.start_offset   = low32(so);
		r.payload_offset = low32(po);
		r.payload_size   = low32(sz);
		r.ref_idc        = 2'((h & anb_pkg::REF_IDC_MASK) >> 5);
		r.unit_type      = 5'(h & anb_pkg::TYPE_MASK);
		r.forbidden_set  = (h & anb_pkg::FORBIDDEN_MASK) != 8'h00;
		r.unit_is_key    = hdr[8] && !r.forbidden_set && !hdr_last &&
			(r.unit_type == anb_pkg::TYPE_IDR || r.unit_type == anb_pkg::TYPE_SPS);
		r.buffer_has_key = key_prev || r.unit_is_key;
		r.unit_valid     = 1'b1;
		r.end_of_buffer  = eob;
		return r;
	endfunction

	off_t       pos_q;
	logic [2:0] zh_q;
	logic [1:0] bss_q;
	logic       open_q;
	off_t       start_q;
	off_t       pay_q;
	logic       hpend_q;
	logic [8:0] hdr_q;
	logic       key_q;

	logic              code;
	off_t              pos_inc;
	off_t              start;
	logic [8:0]        hdr_eff;
	logic              have_close;
	logic              key_after;
	anb_pkg::anb_rec_t close_rec;
	anb_pkg::anb_rec_t end_rec;

	// Detect a start code completing on this byte and work out its offsets
	always_comb begin
		hdr_eff = hpend_q ? {1'b1, byte_s1.data_byte} : hdr_q;
		code    = (byte_s1.data_byte == anb_pkg::START_BYTE) && (zh_q[1:0] == 2'b11) &&
			(bss_q >= 2'd2);
		pos_inc = (pos_q == POS_MAX) ? POS_MAX : off_t'(pos_q + 1'b1);
		start   = (zh_q[2] && bss_q == 2'd3) ? sat_sub(pos_q, off_t'(3)) :
			sat_sub(pos_q, off_t'(2));
		have_close = open_q && code;
		close_rec  = mk_rec(start_q, pay_q, sat_sub(start, pay_q), hdr_eff, 1'b0, key_q,
			1'b0);
		key_after  = key_q || (have_close && close_rec.unit_is_key);
	end

	// End-of-buffer record: fresh unit, open unit, or the invalid record
	always_comb begin
		priority if (code) begin
			end_rec = mk_rec(start, pos_inc, '0, 9'h000, 1'b0, key_after, 1'b1);
		end else if (open_q) begin
			end_rec = mk_rec(start_q, pay_q, sat_sub(pos_inc, pay_q), hdr_eff, hpend_q,
				key_q, 1'b1);
		end else begin
			end_rec               = '0;
			end_rec.end_of_buffer = 1'b1;
		end
	end

	// Pack records in stream order
	always_comb begin
		push.rec_a = have_close ? close_rec : end_rec;
		push.rec_b = end_rec;
		push.cnt   = fire ? (2'(have_close) + 2'(byte_s1.last_byte)) : 2'd0;
	end

	// Advance scan state on each consumed byte; clear it after the buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			zh_q    <= '0;
			bss_q   <= '0;
			open_q  <= 1'b0;
			start_q <= '0;
			pay_q   <= '0;
			hpend_q <= 1'b0;
			hdr_q   <= '0;
			key_q   <= 1'b0;
		end else if (fire) begin
			if (byte_s1.last_byte) begin
				pos_q   <= '0;
				zh_q    <= '0;
				bss_q   <= '0;
				open_q  <= 1'b0;
				start_q <= '0;
				pay_q   <= '0;
				hpend_q <= 1'b0;
				hdr_q   <= '0;
				key_q   <= 1'b0;
			end else begin
				pos_q <= pos_inc;
				key_q <= key_after;
				if (code) begin
					open_q  <= 1'b1;
					start_q <= start;
					pay_q   <= pos_inc;
					hpend_q <= 1'b1;
					hdr_q   <= '0;
					zh_q    <= '0;
					bss_q   <= '0;
				end else begin
					zh_q  <= {zh_q[1:0], byte_s1.data_byte == 8'h00};
					bss_q <= (bss_q == 2'd3) ? 2'd3 : 2'(bss_q + 1'b1);
					if (hpend_q) begin
						hdr_q   <= {1'b1, byte_s1.data_byte};
						hpend_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

FILE: rtl/core/anb_rec_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_rec_fifo
// Result queue: takes up to two records a cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module anb_rec_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  anb_pkg::anb_push_t push,
	anb_rec_if.source          units,
	output logic               room,
	output logic [2:0]         level
);

	localparam int unsigned PW = $clog2(anb_pkg::FIFO_DEPTH);

	anb_pkg::anb_rec_t    mem_q [anb_pkg::FIFO_DEPTH];
	logic [PW-1:0]        wptr_q;
	logic [PW-1:0]        rptr_q;
	logic [2:0]           cnt_q;
	logic                 pop;
	anb_pkg::anb_rec_t    head;

	assign pop   = units.valid && units.ready;
	assign room  = cnt_q <= 3'(anb_pkg::FIFO_DEPTH - 2);
	assign level = cnt_q;
	assign head  = mem_q[rptr_q];

	// Present the head entry
	assign units.valid          = cnt_q != 3'd0;
	assign units.start_offset   = head.start_offset;
	assign units.payload_offset = head.payload_offset;
	assign units.payload_size   = head.payload_size;
	assign units.ref_idc        = head.ref_idc;
	assign units.unit_type      = head.unit_type;
	assign units.forbidden_set  = head.forbidden_set;
	assign units.unit_is_key    = head.unit_is_key;
	assign units.buffer_has_key = head.buffer_has_key;
	assign units.unit_valid     = head.unit_valid;
	assign units.end_of_buffer  = head.end_of_buffer;

	// Write up to two entries
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wptr_q] <= push.rec_a;
		end
		if (push.cnt == 2'd2) begin
			mem_q[PW'(wptr_q + 1'b1)] <= push.rec_b;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= PW'(wptr_q + push.cnt);
			rptr_q <= PW'(rptr_q + pop);
			cnt_q  <= 3'(cnt_q + push.cnt - 3'(pop));
		end
	end

endmodule

FILE: rtl/core/annexb_nal_unit_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_scanner_core
// Annex B start-code scanner producing one record per found unit.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the queue has room and finds 00 00 01 and
// 00 00 00 01 start codes. Each byte moves from the input register through
// the scan logic into a four-entry record queue, so the sustained rate is one
// byte per clock while the queue has room; records leave one per transfer. A
// byte that closes a unit and ends the buffer yields two records, and the
// scan stage holds a byte whenever the queue has fewer than two free entries.
// Offsets saturate at 2^OFFSET_BITS-1 and are reported in 32 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module annexb_nal_unit_scanner_core #(
	parameter int unsigned OFFSET_BITS = anb_pkg::OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	anb_byte_if.sink   stream,
	anb_rec_if.source  units
);

	logic               valid_s1;
	anb_pkg::anb_byte_t byte_s1;
	logic               room;
	logic [2:0]         level;
	logic               fire;
	anb_pkg::anb_push_t push;

	// Consume the held byte when the queue can take two records
	assign fire = valid_s1 && room;

	anb_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	anb_scan #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.push    (push)
	);

	anb_rec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.units  (units),
		.room   (room),
		.level  (level)
	);

	// Queue never overfills
	`CHK_IMPLY(a_level_bound, 1'b1, level <= 3'(anb_pkg::FIFO_DEPTH))
	// Invalid record is only ever an end record with zero offsets
	`CHK_IMPLY(a_invalid_rec, units.valid && !units.unit_valid,
		units.end_of_buffer && units.start_offset == 32'd0 && units.payload_size == 32'd0)
	// A held byte with a full queue blocks new input
	`CHK_IMPLY(a_stall_in, valid_s1 && !room, !stream.ready)
	// Records pushed are visible on the next cycle
	`CHK_NEXT(a_push_seen, push.cnt != 2'd0, units.valid)

endmodule

FILE: dv/annexb_nal_unit_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_scanner_core_tb
// Self-checking bench for the Annex B unit scanner core.
// ----------------------------------------------------------------------------
// Feeds byte buffers through the stream channel and checks each unit record
// against a cycle-free model of the scanner kept in this file. A short
// directed table covers empty buffers, bare start codes, four-byte codes,
// forbidden headers, a code on the final byte and a header on the final byte.
// Random buffers follow, mostly well-formed units with random headers and
// payloads plus noise, under four mixes of source idling and sink stalls,
// with one long sink hold-off that backs the core up to its input.
// ----------------------------------------------------------------------------
module annexb_nal_unit_scanner_core_tb;

	localparam int unsigned   CYCLE_LIMIT = 400000;
	localparam int unsigned   HOLD_CYCLES = 200;
	localparam int unsigned   BYTES_PER_PHASE = 200;
	localparam int            SRC_IDLE [4] = '{0, 83, 0, 29};
	localparam int            SINK_STALL [4] = '{0, 0, 83, 29};
	localparam logic [63:0]   POS_MAX = {64{1'b1}} >> (64 - anb_pkg::OFFSET_BITS_DEF);

	localparam anb_pkg::anb_rec_t NO_REC = '0;
	// Buffer without any start code
	localparam anb_pkg::anb_rec_t EMPTY_BUF_REC = '{end_of_buffer: 1'b1, default: '0};
	// 00 00 01 ending the buffer: unit with no header and no payload
	localparam anb_pkg::anb_rec_t BARE_CODE_REC = '{payload_offset: 32'd3,
		unit_valid: 1'b1, end_of_buffer: 1'b1, default: '0};

	typedef struct {
		logic [7:0]        data;
		logic              last;
		bit                typed;
		anb_pkg::anb_rec_t want;
	} byte_row_t;

	// Directed table: typed rows carry their record, the rest go to the model
	byte_row_t directed_rows [26] = '{
		'{8'h00, 1'b1, 1'b1, EMPTY_BUF_REC},
		'{8'hff, 1'b1, 1'b1, EMPTY_BUF_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h01, 1'b1, 1'b1, BARE_CODE_REC},
		// four-byte code, IDR header, one payload byte
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h01, 1'b0, 1'b0, NO_REC},
		'{8'h65, 1'b0, 1'b0, NO_REC},
		'{8'haa, 1'b1, 1'b0, NO_REC},
		// forbidden bit on an SPS header, then a code on the final byte
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h01, 1'b0, 1'b0, NO_REC},
		'{8'he7, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h01, 1'b1, 1'b0, NO_REC},
		// key unit, then an IDR header that is the final byte
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h01, 1'b0, 1'b0, NO_REC},
		'{8'h45, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h00, 1'b0, 1'b0, NO_REC},
		'{8'h01, 1'b0, 1'b0, NO_REC},
		'{8'h05, 1'b1, 1'b0, NO_REC}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	anb_byte_if stream ();
	anb_rec_if  units ();

	annexb_nal_unit_scanner_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.units  (units)
	);

	always #2 clk = ~clk;

	// Scanner state as seen by the model
	logic [63:0] scan_pos;
	logic [2:0]  zero_run;
	logic [1:0]  since_code;
	bit          unit_open;
	logic [63:0] open_start;
	logic [63:0] open_payload;
	bit          header_due;
	logic [8:0]  header_bits;
	bit          key_in_buffer;

	anb_pkg::anb_rec_t expected_units [$];
	byte_row_t         byte_notes [$];

	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned n_bytes = 0;
	int unsigned n_buffers = 0;
	int unsigned n_records = 0;
	int unsigned n_key = 0;
	int unsigned n_empty = 0;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;

	function automatic logic [63:0] sat_inc(input logic [63:0] x);
		return (x >= POS_MAX) ? POS_MAX : x + 64'd1;
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic void reset_scan();
		scan_pos = '0;
		zero_run = '0;
		since_code = '0;
		unit_open = 1'b0;
		open_start = '0;
		open_payload = '0;
		header_due = 1'b0;
		header_bits = '0;
		key_in_buffer = 1'b0;
	endfunction

	// Build the record of the open unit and track the buffer key flag
	function automatic anb_pkg::anb_rec_t close_unit(input logic [63:0] size,
		input bit header_last, input bit eob);
		logic [7:0]        h;
		logic [4:0]        ty;
		bit                key;
		anb_pkg::anb_rec_t r;
		h = header_bits[8] ? header_bits[7:0] : 8'h00;
		ty = 5'(h & anb_pkg::TYPE_MASK);
		key = header_bits[8] && ((h & anb_pkg::FORBIDDEN_MASK) == 8'h00)
			&& (ty == anb_pkg::TYPE_IDR || ty == anb_pkg::TYPE_SPS) && !header_last;
		if (key)
			key_in_buffer = 1'b1;
		r.start_offset = open_start[31:0];
		r.payload_offset = open_payload[31:0];
		r.payload_size = size[31:0];
		r.ref_idc = 2'((h & anb_pkg::REF_IDC_MASK) >> 5);
		r.unit_type = ty;
		r.forbidden_set = |(h & anb_pkg::FORBIDDEN_MASK);
		r.unit_is_key = key;
		r.buffer_has_key = key_in_buffer;
		r.unit_valid = 1'b1;
		r.end_of_buffer = eob;
		return r;
	endfunction

	// Advance the model by one byte; returns the number of records it causes
	function automatic int scan_byte(input logic [7:0] b, input logic last,
		output anb_pkg::anb_rec_t r0, output anb_pkg::anb_rec_t r1);
		logic [63:0]       here;
		logic [63:0]       code_at;
		bit                header_now;
		int                n;
		anb_pkg::anb_rec_t r [2];
		here = scan_pos;
		header_now = 1'b0;
		n = 0;
		r[0] = '0;
		r[1] = '0;
		if (header_due) begin
			header_bits = {1'b1, b};
			header_due = 1'b0;
			header_now = 1'b1;
		end
		// start code completes here: close the open unit, open a new one
		if (b == anb_pkg::START_BYTE && zero_run[1:0] == 2'b11 && since_code >= 2) begin
			if (zero_run[2] && since_code == 2'd3)
				code_at = sat_sub(here, 64'd3);
			else
				code_at = sat_sub(here, 64'd2);
			if (unit_open) begin
				r[n] = close_unit(sat_sub(code_at, open_payload), 1'b0, 1'b0);
				n++;
			end
			unit_open = 1'b1;
			open_start = code_at;
			open_payload = sat_inc(here);
			header_due = 1'b1;
			header_bits = '0;
			header_now = 1'b0;
			zero_run = '0;
			since_code = '0;
		end else begin
			zero_run = {zero_run[1:0], b == 8'h00};
			if (since_code != 2'd3)
				since_code++;
		end
		if (last) begin
			if (unit_open)
				r[n] = close_unit(sat_sub(sat_inc(here), open_payload), header_now, 1'b1);
			else
				r[n] = EMPTY_BUF_REC;
			n++;
			reset_scan();
		end else begin
			scan_pos = sat_inc(here);
		end
		r0 = r[0];
		r1 = r[1];
		return n;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Offer one byte, idling first at the current source rate
	task automatic offer_byte(input logic [7:0] b, input logic last, input bit typed,
		input anb_pkg::anb_rec_t want);
		byte_row_t note;
		note = '{b, last, typed, want};
		if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
			stream.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(1, 100) <= src_idle_pct);
		end
		byte_notes = {byte_notes, note};
		stream.valid <= 1'b1;
		stream.data_byte <= b;
		stream.last_byte <= last;
		do
			@(posedge clk);
		while (!stream.ready);
		n_bytes++;
	endtask

	// Stop sending and wait for every outstanding record
	task automatic settle();
		stream.valid <= 1'b0;
		@(posedge clk);
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Predict on every accepted byte
	always @(posedge clk) begin : watch_bytes
		byte_row_t         note;
		anb_pkg::anb_rec_t ra;
		anb_pkg::anb_rec_t rb;
		int                n;
		if (arst_n && stream.valid && stream.ready) begin
			note = byte_notes.pop_front();
			n = scan_byte(stream.data_byte, stream.last_byte, ra, rb);
			if (stream.last_byte)
				n_buffers++;
			if (note.typed) begin
				expected_units = {expected_units, note.want};
			end else begin
				if (n > 0)
					expected_units = {expected_units, ra};
				if (n > 1)
					expected_units = {expected_units, rb};
			end
		end
	end

	// Check every record transfer against the oldest expectation
	always @(posedge clk) begin : watch_units
		anb_pkg::anb_rec_t got;
		anb_pkg::anb_rec_t want;
		if (arst_n && units.valid && units.ready) begin
			got.start_offset = units.start_offset;
			got.payload_offset = units.payload_offset;
			got.payload_size = units.payload_size;
			got.ref_idc = units.ref_idc;
			got.unit_type = units.unit_type;
			got.forbidden_set = units.forbidden_set;
			got.unit_is_key = units.unit_is_key;
			got.buffer_has_key = units.buffer_has_key;
			got.unit_valid = units.unit_valid;
			got.end_of_buffer = units.end_of_buffer;
			n_records++;
			if (got.unit_is_key === 1'b1)
				n_key++;
			if (got.unit_valid === 1'b0)
				n_empty++;
			if (expected_units.size() == 0) begin
				errors++;
				$display("%0t: unexpected record, expected none, actual start %0d size %0d",
					$time, got.start_offset, got.payload_size);
			end else begin
				want = expected_units.pop_front();
				check_field("start_offset", want.start_offset, got.start_offset);
				check_field("payload_offset", want.payload_offset, got.payload_offset);
				check_field("payload_size", want.payload_size, got.payload_size);
				check_field("ref_idc", want.ref_idc, got.ref_idc);
				check_field("unit_type", want.unit_type, got.unit_type);
				check_field("forbidden_set", want.forbidden_set, got.forbidden_set);
				check_field("unit_is_key", want.unit_is_key, got.unit_is_key);
				check_field("buffer_has_key", want.buffer_has_key, got.buffer_has_key);
				check_field("unit_valid", want.unit_valid, got.unit_valid);
				check_field("end_of_buffer", want.end_of_buffer, got.end_of_buffer);
			end
		end
	end

	// Record sink: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			units.ready <= 1'b0;
		end else if (hold_left != 0) begin
			units.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			units.ready <= 1'b0;
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			units.ready <= ($urandom_range(1, 100) > sink_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached, %0d records outstanding", $time,
				expected_units.size());
			$display("annexb_nal_unit_scanner_core_tb: errors");
			$finish;
		end
	end

	initial begin
		int          phase;
		int unsigned target;
		int          kind;
		int          n_units;
		int          len;
		logic [7:0]  hdr;
		logic [7:0]  frame_bytes [$];
		stream.valid = 1'b0;
		stream.data_byte = 8'h00;
		stream.last_byte = 1'b0;
		units.ready = 1'b0;
		reset_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (directed_rows[i])
			offer_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].want);
		settle();

		// Random buffers under each idle/stall mix
		for (phase = 0; phase < 4; phase++) begin
			src_idle_pct = SRC_IDLE[phase];
			sink_stall_pct = SINK_STALL[phase];
			target = n_bytes + BYTES_PER_PHASE;
			while (n_bytes < target) begin
				// hold the sink off while the source keeps going
				if (phase == 0 && hold_requests == 0 && n_bytes + 120 >= target)
					hold_requests++;
				frame_bytes.delete();
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					// well-formed units after a little leading junk
					repeat ($urandom_range(0, 2))
						frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
					n_units = $urandom_range(1, 4);
					for (int u = 0; u < n_units; u++) begin
						repeat ($urandom_range(2, 4))
							frame_bytes = {frame_bytes, 8'h00};
						frame_bytes = {frame_bytes, anb_pkg::START_BYTE};
						if (u == n_units - 1 && $urandom_range(0, 9) == 0)
							break;
						hdr = 8'($urandom_range(0, 255));
						case ($urandom_range(0, 3))
							0: hdr[4:0] = anb_pkg::TYPE_IDR;
							1: hdr[4:0] = anb_pkg::TYPE_SPS;
							default: ;
						endcase
						if ($urandom_range(0, 3) != 0)
							hdr = hdr & ~anb_pkg::FORBIDDEN_MASK;
						frame_bytes = {frame_bytes, hdr};
						len = (u == n_units - 1 && $urandom_range(0, 7) == 0) ? 0
							: $urandom_range(0, 10);
						repeat (len) begin
							case ($urandom_range(0, 7))
								0, 1: frame_bytes = {frame_bytes, 8'h00};
								2: begin
									// zero run broken by an escape byte
									frame_bytes = {frame_bytes, 8'h00, 8'h00, 8'h03};
								end
								3: begin
									// one zero before 01: a code only when another zero comes before it
									frame_bytes = {frame_bytes, 8'h00, anb_pkg::START_BYTE};
								end
								default: frame_bytes = {frame_bytes,
									8'($urandom_range(1, 255))};
							endcase
						end
					end
				end else begin
					// noise, zero-heavy
					repeat ($urandom_range(1, 12))
						frame_bytes = {frame_bytes, (($urandom_range(0, 2) == 0) ? 8'h00
							: 8'($urandom_range(0, 255)))};
				end
				foreach (frame_bytes[i])
					offer_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_REC);
			end
			settle();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d bytes in %0d buffers; %0d records checked, %0d key, %0d empty.",
			n_bytes, n_buffers, n_records, n_key, n_empty);
		$display("Four source/sink idle mixes and one %0d-cycle sink hold-off were run.",
			HOLD_CYCLES);
		if (errors == 0 && expected_units.size() == 0)
			$display("annexb_nal_unit_scanner_core_tb: clean");
		else
			$display("annexb_nal_unit_scanner_core_tb: errors");
		$finish;
	end

endmodule
